// ----- hdl/fms_pkg.sv -----
// Shared types and constants for the fact mutex store.
package fms_pkg;

  localparam int FACT_W = 6;
  localparam int MASK_W = 64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [FACT_W-1:0] fact_index;
    logic              last;
  } fms_req_t;

  typedef struct packed {
    logic is_mutex;
    logic status;
  } fms_rsp_t;

endpackage

// ----- hdl/fact_mutex_store.sv -----
// Top level of the fact mutex store: sequencer, pending set and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------
//  in      | input     | in_valid_i / in_stall_o   | in_req_i  (fms_req_t)
//  out     | output    | out_valid_o / out_stall_i | out_rsp_o (fms_rsp_t)
//
// A request that does not close is accepted, then checked against its matrix row.
// A closing add of a large group is stored in the group table if it is not full; one
// that marks the matrix does a read-modify-write of one or two rows through the single
// matrix port. A closing query with no pair hit scans the stored large groups in turn.
// Reset clears the matrix through per-row valid bits at once; no clearing pass.
// A stalled result is held in the output register; the next request is taken meanwhile.
module fact_mutex_store #(
  parameter int NUM_FACTS = 64,
  parameter int MAX_LARGE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fms_pkg::fms_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fms_pkg::fms_rsp_t out_rsp_o
);
  import fms_pkg::*;

  localparam int FIDX_W = $clog2(NUM_FACTS);
  localparam int CNT_W  = $clog2(MAX_LARGE + 1);
  localparam int LG_AW  = (MAX_LARGE > 1) ? $clog2(MAX_LARGE) : 1;
  localparam logic [FACT_W:0] NF_LIM = (FACT_W + 1)'(NUM_FACTS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LARGE);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_MK_RA, S_MK_WA, S_MK_WB, S_SC_RD, S_SC_CMP, S_OUT
  } state_e;

  typedef enum logic [1:0] {SZ_NONE, SZ_ONE, SZ_TWO, SZ_MANY} size_e;

  state_e             state_q;
  fms_req_t           item_q;
  logic [MASK_W-1:0]  pend_q, pend_d;
  size_e              size_q, size_d;
  logic [FACT_W-1:0]  f1_q, f1_d, f2_q, f2_d;
  logic               hit_q, hit_d;
  logic [CNT_W-1:0]   cnt_q, scan_q, scan_d;
  fms_rsp_t           res_q, out_rsp_q;
  logic               out_vld_q;

  logic               new_fact, in_range, f1_ok, f2_ok, mark_ok, tab_full;
  logic [FACT_W-1:0]  mk_b;
  logic [MASK_W-1:0]  opa, opb, tab_rd;
  logic               unit_zero;
  logic [NUM_FACTS-1:0] pm_rd_row, pm_wr_row;
  logic [FIDX_W-1:0]  pm_rd_addr, pm_wr_addr;
  logic               pm_we, tab_we;
  fms_rsp_t           chk_rsp;
  logic               out_load;

  // pending set update for the item held in item_q
  always_comb begin
    new_fact = !pend_q[item_q.fact_index];
    pend_d   = pend_q | (MASK_W'(1) << item_q.fact_index);
    size_d   = size_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    if (new_fact && size_q != SZ_MANY) begin
      size_d = size_e'(size_q + 2'd1);
    end
    if (new_fact && size_q == SZ_NONE) begin
      f1_d = item_q.fact_index;
    end
    if (new_fact && size_q == SZ_ONE) begin
      f2_d = item_q.fact_index;
    end
  end

  assign in_range = ({1'b0, item_q.fact_index} < NF_LIM);
  assign f1_ok    = ({1'b0, f1_d} < NF_LIM);
  assign f2_ok    = ({1'b0, f2_d} < NF_LIM);
  assign mark_ok  = (size_d == SZ_ONE) ? f1_ok : (f1_ok && f2_ok);
  assign tab_full = (cnt_q == CNT_MAX);
  assign hit_d    = hit_q || (item_q.operation == OP_QUERY && in_range && !unit_zero);
  assign scan_d   = scan_q + CNT_W'(1);
  assign mk_b     = (size_q == SZ_ONE) ? f1_q : f2_q;

  // result as known at the check step; a query scan may still set the mutex flag
  always_comb begin
    chk_rsp = '0;
    if (item_q.operation == OP_ADD) begin
      chk_rsp.status = (size_d == SZ_MANY && tab_full) ? ST_FULL : ST_OK;
    end else begin
      chk_rsp.is_mutex = hit_d;
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_vld_q || !out_stall_i);

  // operands of the shared mask unit
  always_comb begin
    unique case (state_q)
      S_CHK: begin
        opa = MASK_W'(pm_rd_row);
        opb = pend_d;
      end
      S_SC_CMP: begin
        opa = tab_rd;
        opb = ~pend_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // matrix port: row fetch on accept, read-modify-write when marking
  always_comb begin
    pm_rd_addr = in_req_i.fact_index[FIDX_W-1:0];
    pm_we      = 1'b0;
    pm_wr_addr = f1_q[FIDX_W-1:0];
    pm_wr_row  = pm_rd_row | (NUM_FACTS'(1) << mk_b[FIDX_W-1:0]);
    unique case (state_q)
      S_MK_RA: pm_rd_addr = f1_q[FIDX_W-1:0];
      S_MK_WA: begin
        pm_rd_addr = mk_b[FIDX_W-1:0];
        pm_we      = 1'b1;
      end
      S_MK_WB: begin
        pm_we      = 1'b1;
        pm_wr_addr = mk_b[FIDX_W-1:0];
        pm_wr_row  = pm_rd_row | (NUM_FACTS'(1) << f1_q[FIDX_W-1:0]);
      end
      default: ;
    endcase
  end

  assign tab_we = (state_q == S_CHK) && item_q.last && (item_q.operation == OP_ADD)
                  && (size_d == SZ_MANY) && !tab_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      item_q    <= '0;
      pend_q    <= '0;
      size_q    <= SZ_NONE;
      f1_q      <= '0;
      f2_q      <= '0;
      hit_q     <= 1'b0;
      cnt_q     <= '0;
      scan_q    <= '0;
      res_q     <= '0;
      out_rsp_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
        out_rsp_q <= res_q;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_req_i;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          pend_q <= pend_d;
          size_q <= size_d;
          f1_q   <= f1_d;
          f2_q   <= f2_d;
          hit_q  <= hit_d;
          res_q  <= chk_rsp;
          if (!item_q.last) begin
            state_q <= S_IDLE;
          end else if (item_q.operation == OP_ADD) begin
            if (size_d == SZ_MANY) begin
              if (!tab_full) begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
              state_q <= S_OUT;
            end else if (mark_ok) begin
              state_q <= S_MK_RA;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            if (hit_d) begin
              state_q <= S_OUT;
            end else if (cnt_q == '0) begin
              state_q <= S_OUT;
            end else begin
              scan_q  <= '0;
              state_q <= S_SC_RD;
            end
          end
        end
        S_MK_RA: state_q <= S_MK_WA;
        // a group of one marks only its diagonal cell
        S_MK_WA: state_q <= (size_q == SZ_ONE) ? S_OUT : S_MK_WB;
        S_MK_WB: state_q <= S_OUT;
        S_SC_RD: state_q <= S_SC_CMP;
        S_SC_CMP: begin
          if (unit_zero) begin
            res_q.is_mutex <= 1'b1;
            state_q        <= S_OUT;
          end else if (scan_d == cnt_q) begin
            state_q <= S_OUT;
          end else begin
            scan_q  <= scan_d;
            state_q <= S_SC_RD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            pend_q    <= '0;
            size_q    <= SZ_NONE;
            hit_q     <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
      endcase
    end
  end

  fms_and_unit u_and (
    .opa_i  (opa),
    .opb_i  (opb),
    .zero_o (unit_zero)
  );

  fms_pair_mat #(
    .NUM_FACTS (NUM_FACTS)
  ) u_pair (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (pm_rd_addr),
    .rd_row_o  (pm_rd_row),
    .wr_en_i   (pm_we),
    .wr_addr_i (pm_wr_addr),
    .wr_row_i  (pm_wr_row)
  );

  fms_grp_tab #(
    .MAX_LARGE (MAX_LARGE),
    .AW        (LG_AW)
  ) u_tab (
    .clk_i     (clk_i),
    .rd_addr_i (scan_q[LG_AW-1:0]),
    .rd_data_o (tab_rd),
    .wr_en_i   (tab_we),
    .wr_addr_i (cnt_q[LG_AW-1:0]),
    .wr_data_i (pend_d)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- hdl/fms_and_unit.sv -----
// Shared mask unit: flags when two 64-bit masks have no common bit.
module fms_and_unit (
  input  logic [fms_pkg::MASK_W-1:0] opa_i,
  input  logic [fms_pkg::MASK_W-1:0] opb_i,
  output logic                       zero_o
);
  import fms_pkg::*;

  assign zero_o = ((opa_i & opb_i) == '0);

endmodule

// ----- hdl/fms_pair_mat.sv -----
// Symmetric pair bit matrix: row memory with per-row valid bits, registered read.
module fms_pair_mat #(
  parameter int NUM_FACTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(NUM_FACTS)-1:0] rd_addr_i,
  output logic [NUM_FACTS-1:0]         rd_row_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(NUM_FACTS)-1:0] wr_addr_i,
  input  logic [NUM_FACTS-1:0]         wr_row_i
);
  import fms_pkg::*;

  logic [NUM_FACTS-1:0] mem [NUM_FACTS];
  logic [NUM_FACTS-1:0] row_vld_q;
  logic [NUM_FACTS-1:0] rd_data_q;
  logic                 rd_vld_q;

  // rows never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[rd_addr_i];
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
  end

  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- hdl/fms_grp_tab.sv -----
// Large group table: one mask per entry, registered read.
module fms_grp_tab #(
  parameter int MAX_LARGE = 16,
  parameter int AW        = 4
) (
  input  logic                       clk_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [fms_pkg::MASK_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [fms_pkg::MASK_W-1:0] wr_data_i
);
  import fms_pkg::*;

  logic [MASK_W-1:0] mem [MAX_LARGE];
  logic [MASK_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/fms_checker.sv -----
// Port-level checks for the fact mutex store, bound to the top level.
module fms_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input fms_pkg::fms_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fms_pkg::fms_rsp_t out_rsp_o
);
  import fms_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted request keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  // a new result appears only at the end of a request's work
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without request in progress");

  // a query result carries ok status, an add result no mutex flag, so never both together
  a_rsp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.is_mutex && out_rsp_o.status == ST_FULL))
    else $error("mutex flag and full status together");

endmodule

bind fact_mutex_store fms_checker u_fms_checker (.*);

// ----- sim/fms_tb_pkg.sv -----
// Scoreboard for the fact mutex store: mirrored store state and queued expected responses.
package fms_tb_pkg;

  import fms_pkg::*;

  class fms_scoreboard #(int NUM_FACTS = 64, int MAX_LARGE = 16);
    logic [63:0] pair_rows [64];
    logic [63:0] groups [MAX_LARGE];
    int unsigned group_cnt;
    logic [63:0] open_mask;
    int unsigned open_size;
    bit          open_hit;
    fms_rsp_t    want_q [$];
    int unsigned errors;

    function new();
      foreach (pair_rows[i]) pair_rows[i] = '0;
      foreach (groups[i]) groups[i] = '0;
      group_cnt = 0;
      open_mask = '0;
      open_size = 0;
      open_hit  = 1'b0;
      errors    = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch %0d: %s", errors, what);
    endtask

    // Facts at or above NUM_FACTS never touch the matrix.
    function void mark_pair(int unsigned a, int unsigned b);
      if (a < NUM_FACTS && b < NUM_FACTS) begin
        pair_rows[a][b] = 1'b1;
        pair_rows[b][a] = 1'b1;
      end
    endfunction

    function logic close_group();
      int unsigned first, second, found, i;
      first  = 0;
      second = 0;
      found  = 0;
      for (i = 0; i < 64; i++) begin
        if (open_mask[i]) begin
          if (found == 0) first = i;
          else if (found == 1) second = i;
          found++;
        end
      end
      if (open_size == 1) begin
        mark_pair(first, first);
      end else if (open_size == 2) begin
        mark_pair(first, second);
      end else if (open_size >= 3) begin
        if (group_cnt < MAX_LARGE) begin
          groups[group_cnt] = open_mask;
          group_cnt++;
        end else begin
          return ST_FULL;
        end
      end
      return ST_OK;
    endfunction

    function logic close_query();
      int unsigned i;
      if (open_hit) return 1'b1;
      for (i = 0; i < group_cnt; i++) begin
        if ((groups[i] & ~open_mask) == '0) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Called for every accepted request; queues a response on a closing one.
    function void note_request(fms_req_t req);
      logic [63:0] fact_bit;
      fms_rsp_t    want;
      fact_bit = 64'd1 << req.fact_index;
      // pair check only on query requests, against everything pending so far
      if (req.operation == OP_QUERY && req.fact_index < NUM_FACTS &&
          (pair_rows[req.fact_index] & (open_mask | fact_bit)) != '0) begin
        open_hit = 1'b1;
      end
      if ((open_mask & fact_bit) == '0) begin
        open_mask |= fact_bit;
        open_size++;
      end
      if (!req.last) return;
      if (req.operation == OP_ADD) begin
        want.is_mutex = 1'b0;
        want.status   = close_group();
      end else begin
        want.is_mutex = close_query();
        want.status   = ST_OK;
      end
      want_q.push_back(want);
      open_mask = '0;
      open_size = 0;
      open_hit  = 1'b0;
    endfunction

    task check_result(fms_rsp_t got);
      fms_rsp_t want;
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: is_mutex=%0b status=%0b",
                                  got.is_mutex, got.status));
        return;
      end
      want = want_q.pop_front();
      if (got.is_mutex !== want.is_mutex)
        report_mismatch($sformatf("is_mutex got %0b want %0b", got.is_mutex, want.is_mutex));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0b want %0b", got.status, want.status));
    endtask
  endclass

endpackage

// ----- sim/tb_top.sv -----
// Testbench top for the fact mutex store: request driver, response monitor and watchdog.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fms_pkg::*;
  import fms_tb_pkg::*;

  localparam int N_FACTS  = 64;
  localparam int N_LARGE  = 16;
  localparam int N_ITEMS  = 1850;
  localparam int WATCHDOG = 5000;
  localparam int DRAIN    = 100;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  fms_req_t in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fms_rsp_t out_rsp;

  fms_scoreboard #(N_FACTS, N_LARGE) sb;

  bit          idle_on      = 1'b1;
  int unsigned sent_cnt     = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  fact_mutex_store #(
    .NUM_FACTS(N_FACTS),
    .MAX_LARGE(N_LARGE)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Starts and ends on a falling edge.
  task automatic send_req(fms_req_t req);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(req);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic send_fact(logic op, int unsigned fact, logic last);
    fms_req_t req;
    req.operation  = op;
    req.fact_index = 6'(fact);
    req.last       = last;
    send_req(req);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_rsp);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    fms_req_t    seq [$];
    fms_req_t    item;
    logic [63:0] used;
    logic        op;
    bit          mixed;
    int unsigned kind, n, f, next_switch;
    int          i, j;

    sb = new();
    next_switch = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // duplicate fact collapses to a one-fact group: marks the diagonal of 63
    send_fact(OP_ADD, 63, 1'b0);
    send_fact(OP_ADD, 63, 1'b1);
    send_fact(OP_ADD, 0, 1'b0);
    send_fact(OP_ADD, 1, 1'b1);
    send_fact(OP_QUERY, 63, 1'b1);
    send_fact(OP_QUERY, 1, 1'b0);
    send_fact(OP_QUERY, 0, 1'b1);
    send_fact(OP_QUERY, 2, 1'b0);
    send_fact(OP_QUERY, 62, 1'b1);
    send_fact(OP_ADD, 5, 1'b0);
    send_fact(OP_ADD, 6, 1'b0);
    send_fact(OP_ADD, 5, 1'b0);
    send_fact(OP_ADD, 7, 1'b1);
    // superset of the stored large group
    send_fact(OP_QUERY, 7, 1'b0);
    send_fact(OP_QUERY, 9, 1'b0);
    send_fact(OP_QUERY, 6, 1'b0);
    send_fact(OP_QUERY, 5, 1'b1);
    send_fact(OP_QUERY, 5, 1'b0);
    send_fact(OP_QUERY, 6, 1'b1);
    // mixed operations: the closing request decides the kind
    send_fact(OP_ADD, 10, 1'b0);
    send_fact(OP_QUERY, 11, 1'b1);
    send_fact(OP_QUERY, 0, 1'b0);
    send_fact(OP_ADD, 1, 1'b1);
    send_fact(OP_ADD, 20, 1'b0);
    send_fact(OP_ADD, 42, 1'b1);

    while (sent_cnt < N_ITEMS) begin
      if (sent_cnt >= N_ITEMS - N_ITEMS / 8) begin
        idle_on = 1'b0;
      end else if (sent_cnt >= next_switch) begin
        idle_on     = ($urandom_range(0, 9) < 7);
        next_switch = sent_cnt + 40 + $urandom_range(0, 80);
      end
      seq.delete();
      used  = '0;
      mixed = 1'b0;
      op    = OP_ADD;
      kind  = $urandom_range(0, 99);
      // singles are rare so the diagonal does not swamp the queries
      if (kind < 2) begin
        n = 1;
      end else if (kind < 27) begin
        n = 2;
      end else if (kind < 50) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 64) : $urandom_range(3, 6);
      end else begin
        op    = OP_QUERY;
        n     = $urandom_range(1, 6);
        mixed = (kind >= 92);
        if (!mixed && sb.group_cnt != 0 && $urandom_range(0, 2) == 0) begin
          used = sb.groups[$urandom_range(0, sb.group_cnt - 1)];
          n    = $countones(used) + $urandom_range(0, 3);
          if (n > 64) n = 64;
        end
      end
      item = '0;
      for (i = 0; i < 64; i++) begin
        if (used[i]) begin
          item.fact_index = 6'(i);
          seq.push_back(item);
        end
      end
      while (seq.size() < n) begin
        f = $urandom_range(0, 63);
        if (!used[f]) begin
          used[f]         = 1'b1;
          item.fact_index = 6'(f);
          seq.push_back(item);
        end
      end
      if ($urandom_range(0, 4) == 0) seq.push_back(seq[$urandom_range(0, seq.size() - 1)]);
      for (i = seq.size() - 1; i > 0; i--) begin
        j      = $urandom_range(0, i);
        item   = seq[i];
        seq[i] = seq[j];
        seq[j] = item;
      end
      for (i = 0; i < seq.size(); i++) begin
        item           = seq[i];
        item.operation = mixed ? logic'($urandom_range(0, 1)) : op;
        item.last      = (i == seq.size() - 1);
        send_req(item);
      end
    end

    in_valid <= 1'b0;
    idle_on = 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
